// ===== design/bamem_pkg.sv =====
// shared types and codes for the byte addressed data memory
package bamem_pkg;

    // access kind codes
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // access size codes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    // one row of the store: four byte lanes, lane 0 at the lowest address
    typedef logic [3:0][7:0] t_row;

    // input beat
    typedef struct packed {
        logic               kind;
        logic signed [31:0] byte_address;
        logic [1:0]         access_size;
        logic [31:0]        write_value;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [31:0] read_value;
        logic        out_of_range;
        logic        unaligned;
        logic        halted_now;
    } t_out_beat;

endpackage

// ===== design/byte_addressed_data_memory_top.sv =====
// big-endian byte addressed data memory with range and alignment checks
// an accepted input beat passes the stage 1 registers, then the output register
// throughput: one beat per cycle when not stalled, set by the single port row memory
// reset: halted flag cleared, then a clearing pass over all ceil(MEM_BYTES/4) rows
// zeroes the store one row per cycle while input is stalled
module byte_addressed_data_memory_top #(
    parameter int MEM_BYTES = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bamem_pkg::t_in_beat  i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bamem_pkg::t_out_beat o_out_beat
);
    import bamem_pkg::*;

    localparam int         ROWS      = (MEM_BYTES + 3) / 4;
    localparam int         RW        = $clog2(ROWS);
    localparam logic [32:0] LAST_BYTE = 33'(MEM_BYTES - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    // storage
    t_row mem [ROWS];

    // control registers
    logic          r_clearing;
    logic [RW-1:0] r_clr_idx;
    logic          r_halted;
    logic          r_s1_vld;
    logic          r_out_vld;

    // stage 1 payload
    t_row          r_rdata;
    logic          r_s1_rd;
    logic [1:0]    r_s1_size;
    logic [1:0]    r_s1_off;
    logic          r_s1_oor;
    logic          r_s1_una;
    logic          r_s1_halt;
    t_out_beat     r_out;

    // stage 0 signals
    logic          s1_adv;
    logic          accept;
    logic [2:0]    nbytes;
    logic [32:0]   last_addr;
    logic          oor;
    logic          una;
    logic          halt_now;
    logic          go;
    logic [RW-1:0] row;
    logic [1:0]    off;
    logic [3:0]    be;
    t_row          wd;
    logic [31:0]   rd_fmt;

    // handshake
    assign s1_adv     = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_clearing || (r_s1_vld && !s1_adv);
    assign accept     = i_in_valid && !o_in_stall;

    // error checks
    always_comb begin
        case (i_in_beat.access_size)
            SZ_BYTE: begin
                nbytes = 3'd1;
                una    = 1'b0;
            end
            SZ_HALF: begin
                nbytes = 3'd2;
                una    = i_in_beat.byte_address[0];
            end
            default: begin
                nbytes = 3'd4;
                una    = |i_in_beat.byte_address[1:0];
            end
        endcase
        last_addr = {1'b0, i_in_beat.byte_address} + 33'(nbytes) - 33'd1;
        oor       = i_in_beat.byte_address[31] || (last_addr > LAST_BYTE);
        halt_now  = r_halted || oor || una;
        go        = accept && !halt_now;
    end

    assign row = i_in_beat.byte_address[RW+1:2];
    assign off = i_in_beat.byte_address[1:0];

    // byte enables and lane data, most significant byte at the lowest address
    always_comb begin
        be = '0;
        wd = '0;
        case (i_in_beat.access_size)
            SZ_BYTE: begin
                be[off] = 1'b1;
                wd[off] = i_in_beat.write_value[7:0];
            end
            SZ_HALF: begin
                be[{off[1], 1'b0}] = 1'b1;
                be[{off[1], 1'b1}] = 1'b1;
                wd[{off[1], 1'b0}] = i_in_beat.write_value[15:8];
                wd[{off[1], 1'b1}] = i_in_beat.write_value[7:0];
            end
            default: begin
                be    = 4'b1111;
                wd[0] = i_in_beat.write_value[31:24];
                wd[1] = i_in_beat.write_value[23:16];
                wd[2] = i_in_beat.write_value[15:8];
                wd[3] = i_in_beat.write_value[7:0];
            end
        endcase
        if (!(go && i_in_beat.kind == KIND_WRITE)) begin
            be = '0;
        end
    end

    // row memory: clearing pass, byte lane writes, registered read
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_idx] <= '0;
        end else begin
            for (int j = 0; j < 4; j++) begin
                if (be[j]) begin
                    mem[row][j] <= wd[j];
                end
            end
        end
        if (accept) begin
            r_rdata <= mem[row];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_halted   <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_ROW) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept) begin
                r_halted <= halt_now;
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rd   <= !halt_now && (i_in_beat.kind == KIND_READ);
            r_s1_size <= i_in_beat.access_size;
            r_s1_off  <= off;
            r_s1_oor  <= oor;
            r_s1_una  <= una;
            r_s1_halt <= halt_now;
        end
    end

    // big-endian read formatting with zero extension, zero for writes and halted accesses
    always_comb begin
        case (r_s1_size)
            SZ_BYTE: rd_fmt = {24'd0, r_rdata[r_s1_off]};
            SZ_HALF: rd_fmt = {16'd0, r_rdata[{r_s1_off[1], 1'b0}],
                               r_rdata[{r_s1_off[1], 1'b1}]};
            default: rd_fmt = {r_rdata[0], r_rdata[1], r_rdata[2], r_rdata[3]};
        endcase
        if (!r_s1_rd) begin
            rd_fmt = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.read_value   <= rd_fmt;
            r_out.out_of_range <= r_s1_oor;
            r_out.unaligned    <= r_s1_una;
            r_out.halted_now   <= r_s1_halt;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

endmodule

// ===== design/bamem_checker.sv =====
// port level checks for the byte addressed data memory, with bind
module bamem_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input bamem_pkg::t_in_beat  i_in_beat,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input bamem_pkg::t_out_beat o_out_beat
);
    import bamem_pkg::*;

    logic r_seen_halt;

    // remember that a delivered beat reported a halt
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_out_beat.halted_now) begin
            r_seen_halt <= 1'b1;
        end
    end

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat changed under stall");

    // halt is sticky across delivered beats
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_halt |-> o_out_beat.halted_now)
        else $error("halt flag dropped");

    // suppressed accesses read zero
    a_halt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.halted_now |-> o_out_beat.read_value == 32'd0)
        else $error("suppressed access returned data");

    // errors always halt
    a_err_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.out_of_range || o_out_beat.unaligned)
        |-> o_out_beat.halted_now)
        else $error("error without halt");

    // input held off while the store clears after reset
    a_reset_stall: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> o_in_stall && !o_out_valid)
        else $error("block active right after reset");

endmodule

bind byte_addressed_data_memory_top bamem_checker u_bamem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);
